// ----- sv/csw_pkg.sv -----
// shared types and constants for the cutoff switching scale block
package csw_pkg;

    localparam int DIST_W   = 24;
    localparam int NORM_W   = 64;
    localparam int SCALE_W  = 31;
    localparam int SLOPE_W  = 33;
    localparam int CFG_W    = 64;
    localparam int CFG_IDX_W = 3;
    localparam int LIMB_W   = 32;

    // register stages from input capture to output register
    localparam int STAGES = 10;

    // positions of the wide multiply stages in the pipe
    localparam int MUL1_FIRST = 3;
    localparam int MUL2_FIRST = 6;
    localparam int OUT_STAGE  = 9;

    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(64'h4000_0000);

    typedef logic [STAGES-1:0] csw_ce_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ELEC_CUTOFF  = 3'd0,
        REG_ELEC_FEATHER = 3'd1,
        REG_ELEC_NORM    = 3'd2,
        REG_VDW_CUTOFF   = 3'd3,
        REG_VDW_FEATHER  = 3'd4,
        REG_VDW_NORM     = 3'd5
    } csw_reg_t;

endpackage

// ----- sv/cutoff_switching_scale.sv -----
// top level of the cutoff switching scale block: config registers, pipe control, two channels
//
// usage
// - input channel: distance (unsigned Q8.16) with in_valid / in_stall; a beat moves
//   at a clock edge where in_valid is high and in_stall is low
// - output channel: elec_scale, vdw_scale (Q1.30, 1.0 = 2^30) and elec_slope,
//   vdw_slope (signed Q8.24, never positive) with out_valid / out_stall
// - config port: cfg_write, cfg_index, cfg_data; six registers, indexes beyond
//   the list are dropped; write only while no beat is in flight
// - throughput: one beat per cycle while out_stall is low; set by the ten-stage
//   pipe, with the two levels of limb multipliers taking three stages each
// - every stage loads whenever it is empty or the stage after it moves, so
//   bubbles close up under a stalled receiver and new beats are taken until
//   all ten stages hold data; in_stall rises only then
// - a stalled output beat holds its payload until it is taken
// - reset: pipe empty, cutoffs and feathers at full scale, norms zero
//   (hard cutoff at the top of the distance range)
module cutoff_switching_scale (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [csw_pkg::DIST_W-1:0]            distance,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [csw_pkg::SCALE_W-1:0]           elec_scale,
    output logic [csw_pkg::SCALE_W-1:0]           vdw_scale,
    output logic signed [csw_pkg::SLOPE_W-1:0]    elec_slope,
    output logic signed [csw_pkg::SLOPE_W-1:0]    vdw_slope,
    input  logic                                  cfg_write,
    input  logic [csw_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [csw_pkg::CFG_W-1:0]             cfg_data
);

    localparam int NS = csw_pkg::STAGES;
    localparam int DW = csw_pkg::DIST_W;
    localparam int NW = csw_pkg::NORM_W;

    // configuration registers
    logic [DW-1:0] elec_cutoff_reg;
    logic [DW-1:0] elec_feather_reg;
    logic [NW-1:0] elec_norm_reg;
    logic [DW-1:0] vdw_cutoff_reg;
    logic [DW-1:0] vdw_feather_reg;
    logic [NW-1:0] vdw_norm_reg;

    // per-stage valid bits and load enables
    logic [NS-1:0]    valid_reg;
    csw_pkg::csw_ce_t ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elec_cutoff_reg  <= '1;
            elec_feather_reg <= '1;
            elec_norm_reg    <= '0;
            vdw_cutoff_reg   <= '1;
            vdw_feather_reg  <= '1;
            vdw_norm_reg     <= '0;
        end
        else if (cfg_write)
        begin
            unique case (csw_pkg::csw_reg_t'(cfg_index))
                csw_pkg::REG_ELEC_CUTOFF:  elec_cutoff_reg  <= cfg_data[DW-1:0];
                csw_pkg::REG_ELEC_FEATHER: elec_feather_reg <= cfg_data[DW-1:0];
                csw_pkg::REG_ELEC_NORM:    elec_norm_reg    <= cfg_data[NW-1:0];
                csw_pkg::REG_VDW_CUTOFF:   vdw_cutoff_reg   <= cfg_data[DW-1:0];
                csw_pkg::REG_VDW_FEATHER:  vdw_feather_reg  <= cfg_data[DW-1:0];
                csw_pkg::REG_VDW_NORM:     vdw_norm_reg     <= cfg_data[NW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // a stage may load when it is empty or its contents move on
    always_comb
    begin
        ce[NS-1] = !valid_reg[NS-1] || !out_stall;
        for (int k = NS - 2; k >= 0; k--)
        begin
            ce[k] = !valid_reg[k] || ce[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ce[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++)
            begin
                if (ce[k])
                    valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    assign in_stall  = !ce[0];
    assign out_valid = valid_reg[NS-1];

    csw_chan u_elec (
        .clk      (clk),
        .ce       (ce),
        .distance (distance),
        .cutoff   (elec_cutoff_reg),
        .feather  (elec_feather_reg),
        .norm     (elec_norm_reg),
        .scale    (elec_scale),
        .slope    (elec_slope)
    );

    csw_chan u_vdw (
        .clk      (clk),
        .ce       (ce),
        .distance (distance),
        .cutoff   (vdw_cutoff_reg),
        .feather  (vdw_feather_reg),
        .norm     (vdw_norm_reg),
        .scale    (vdw_scale),
        .slope    (vdw_slope)
    );

    // input is held off only when every stage is full and the receiver stalls
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&valid_reg) && out_stall)
        else $error("input stalled with room in the pipe");

    // a new output beat comes from the stage before the last pipe stage
    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(valid_reg[NS-2]))
        else $error("output beat without a source beat");

    // scales never exceed 1.0
    a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (elec_scale <= csw_pkg::SCALE_ONE) && (vdw_scale <= csw_pkg::SCALE_ONE))
        else $error("scale above 1.0");

    // slopes are never positive
    a_slope_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (elec_slope[csw_pkg::SLOPE_W-1] || elec_slope == '0)
                   && (vdw_slope[csw_pkg::SLOPE_W-1] || vdw_slope == '0))
        else $error("positive slope");

endmodule

// ----- sv/csw_wide_mul.sv -----
// exact wide unsigned multiplier over 32 bit limbs, three register stages
module csw_wide_mul #(
    parameter int WA = 48,
    parameter int WB = 64
) (
    input  logic               clk,
    input  logic [2:0]         ce,
    input  logic [WA-1:0]      a,
    input  logic [WB-1:0]      b,
    output logic [WA+WB-1:0]   p
);

    localparam int LW  = csw_pkg::LIMB_W;
    localparam int PPW = 2 * LW;
    localparam int NA  = (WA + LW - 1) / LW;
    localparam int NB  = (WB + LW - 1) / LW;
    localparam int AW  = NA * LW;
    localparam int BW  = NB * LW;
    localparam int RW  = LW * (NB + 1);
    localparam int PW  = LW * (NA + NB);
    localparam int OW  = WA + WB;

    logic [AW-1:0]  a_ext;
    logic [BW-1:0]  b_ext;
    logic [PPW-1:0] pp_reg [NA][NB];
    logic [RW-1:0]  ev [NA];
    logic [RW-1:0]  od [NA];
    logic [RW-1:0]  row_next [NA];
    logic [RW-1:0]  row_reg [NA];
    logic [PW-1:0]  acc;
    logic [OW-1:0]  prod_reg;

    assign a_ext = AW'(a);
    assign b_ext = BW'(b);

    // limb partial products
    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= PPW'(a_ext[i*LW +: LW]) * PPW'(b_ext[j*LW +: LW]);
                end
            end
        end
    end

    // one row per a limb: even and odd products do not overlap, so one add
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            ev[i] = '0;
            od[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                if ((j & 1) == 0)
                    ev[i][j*LW +: PPW] = pp_reg[i][j];
                else
                    od[i][j*LW +: PPW] = pp_reg[i][j];
            end
            row_next[i] = ev[i] + od[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[1])
        begin
            for (int i = 0; i < NA; i++)
            begin
                row_reg[i] <= row_next[i];
            end
        end
    end

    // rows shifted by limb position
    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            acc = acc + (PW'(row_reg[i]) << (LW * i));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[2])
            prod_reg <= acc[OW-1:0];
    end

    assign p = prod_reg;

endmodule

// ----- sv/csw_chan.sv -----
// one switching channel: band test, squares, polynomial terms, wide products, saturation
module csw_chan (
    input  logic                                clk,
    input  csw_pkg::csw_ce_t                    ce,
    input  logic [csw_pkg::DIST_W-1:0]          distance,
    input  logic [csw_pkg::DIST_W-1:0]          cutoff,
    input  logic [csw_pkg::DIST_W-1:0]          feather,
    input  logic [csw_pkg::NORM_W-1:0]          norm,
    output logic [csw_pkg::SCALE_W-1:0]         scale,
    output logic signed [csw_pkg::SLOPE_W-1:0]  slope
);

    localparam int DW   = csw_pkg::DIST_W;
    localparam int SQW  = 2 * DW;
    localparam int BPW  = SQW + 2;
    localparam int D12W = DW + 4;
    localparam int PAW  = SQW + csw_pkg::NORM_W;
    localparam int Q1W  = SQW + BPW;
    localparam int Q2W  = D12W + SQW;
    localparam int SPW  = PAW + Q1W;
    localparam int TPW  = PAW + Q2W;
    localparam int SW   = csw_pkg::SCALE_W;
    localparam int LW   = csw_pkg::SLOPE_W;
    localparam int OS   = csw_pkg::OUT_STAGE;

    logic [DW-1:0]   f_min;
    logic [DW-1:0]   d0_reg;
    logic [DW-1:0]   f0_reg;
    logic [DW-1:0]   d1_reg;
    logic [SQW-1:0]  c2_reg;
    logic [SQW-1:0]  f2_reg;
    logic [SQW-1:0]  r2_reg;
    logic [SQW-1:0]  c2mf2;
    logic [SQW-1:0]  a_next;
    logic [SQW-1:0]  dd_next;
    logic [BPW-1:0]  b_next;
    logic [D12W-1:0] d12_next;
    logic [SQW-1:0]  a_reg;
    logic [SQW-1:0]  dd_reg;
    logic [BPW-1:0]  b_reg;
    logic [D12W-1:0] d12_reg;
    logic [PAW-1:0]  pa;
    logic [Q1W-1:0]  q1;
    logic [Q2W-1:0]  q2;
    logic [SPW-1:0]  sprod;
    logic [TPW-1:0]  tprod;
    logic [OS-1:0]   below_reg;
    logic [OS-1:0]   above_reg;
    logic [SW-1:0]   scale_next;
    logic [LW-1:0]   mag;
    logic [LW-1:0]   slope_next;
    logic [SW-1:0]   scale_reg;
    logic signed [LW-1:0] slope_reg;

    // feather clamped to cutoff
    assign f_min = (feather < cutoff) ? feather : cutoff;

    always_ff @(posedge clk)
    begin
        if (ce[0])
        begin
            d0_reg       <= distance;
            f0_reg       <= f_min;
            below_reg[0] <= distance < f_min;
            above_reg[0] <= distance > cutoff;
        end
        for (int k = 1; k < OS; k++)
        begin
            if (ce[k])
            begin
                below_reg[k] <= below_reg[k-1];
                above_reg[k] <= above_reg[k-1];
            end
        end
    end

    // squares, Q16.32
    always_ff @(posedge clk)
    begin
        if (ce[1])
        begin
            c2_reg <= SQW'(cutoff) * SQW'(cutoff);
            f2_reg <= SQW'(f0_reg) * SQW'(f0_reg);
            r2_reg <= SQW'(d0_reg) * SQW'(d0_reg);
            d1_reg <= d0_reg;
        end
    end

    // band terms; values outside the band are masked at the output
    always_comb
    begin
        a_next   = c2_reg - r2_reg;
        dd_next  = r2_reg - f2_reg;
        c2mf2    = c2_reg - f2_reg;
        b_next   = BPW'(c2mf2) + (BPW'(dd_next) << 1);
        d12_next = (D12W'(d1_reg) << 3) + (D12W'(d1_reg) << 2);
    end

    always_ff @(posedge clk)
    begin
        if (ce[2])
        begin
            a_reg   <= a_next;
            dd_reg  <= dd_next;
            b_reg   <= b_next;
            d12_reg <= d12_next;
        end
    end

    // first product level: a*norm, a*b, 12d*dd
    csw_wide_mul #(.WA(SQW), .WB(csw_pkg::NORM_W)) u_mul_an (
        .clk (clk),
        .ce  (ce[csw_pkg::MUL1_FIRST +: 3]),
        .a   (a_reg),
        .b   (norm),
        .p   (pa)
    );

    csw_wide_mul #(.WA(SQW), .WB(BPW)) u_mul_ab (
        .clk (clk),
        .ce  (ce[csw_pkg::MUL1_FIRST +: 3]),
        .a   (a_reg),
        .b   (b_reg),
        .p   (q1)
    );

    csw_wide_mul #(.WA(D12W), .WB(SQW)) u_mul_dd (
        .clk (clk),
        .ce  (ce[csw_pkg::MUL1_FIRST +: 3]),
        .a   (d12_reg),
        .b   (dd_reg),
        .p   (q2)
    );

    // second product level: a^2 b norm and 12 d a dd norm
    csw_wide_mul #(.WA(PAW), .WB(Q1W)) u_mul_scale (
        .clk (clk),
        .ce  (ce[csw_pkg::MUL2_FIRST +: 3]),
        .a   (pa),
        .b   (q1),
        .p   (sprod)
    );

    csw_wide_mul #(.WA(PAW), .WB(Q2W)) u_mul_slope (
        .clk (clk),
        .ce  (ce[csw_pkg::MUL2_FIRST +: 3]),
        .a   (pa),
        .b   (q2),
        .p   (tprod)
    );

    // truncate and saturate: scale >> 114 to 1.0, slope >> 104 to 2^32
    always_comb
    begin
        mag = (|tprod[TPW-1:136]) ? (LW'(1) << 32) : LW'(tprod[135:104]);
        if (below_reg[OS-1])
        begin
            scale_next = csw_pkg::SCALE_ONE;
            slope_next = '0;
        end
        else if (above_reg[OS-1])
        begin
            scale_next = '0;
            slope_next = '0;
        end
        else
        begin
            scale_next = (|sprod[SPW-1:144]) ? csw_pkg::SCALE_ONE : SW'(sprod[143:114]);
            slope_next = LW'(0) - mag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce[OS])
        begin
            scale_reg <= scale_next;
            slope_reg <= $signed(slope_next);
        end
    end

    assign scale = scale_reg;
    assign slope = slope_reg;

endmodule
